// ===== design/scc_pkg.sv =====
package scc_pkg;

  // Default graph size handed to the top level parameter
  localparam int unsigned DEF_MAX_VERTICES = 1024;
  // Colours are stored in six bits, so the usable colour count tops out here
  localparam int unsigned MAX_COLORS = 64;

  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned COLOR_W    = 6;
  localparam int unsigned VALUE_W    = 20;
  localparam int unsigned NVERTS_W   = 11;
  localparam int unsigned NCOLORS_W  = 7;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Input commands
  localparam logic [1:0] CMD_LOAD_ADJ  = 2'd0;
  localparam logic [1:0] CMD_SET_COLOR = 2'd1;
  localparam logic [1:0] CMD_CONFLICT  = 2'd2;
  localparam logic [1:0] CMD_ENERGY    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORBID_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLORS  = 2'd2;

  typedef struct packed {
    logic [WORD_BITS-1:0] fmask;
    logic [NVERTS_W-1:0]  nverts;
    logic [NCOLORS_W-1:0] ncolors;
  } cfg_t;

  // Position of the lowest set bit; zero when no bit is set
  function automatic logic [5:0] lsb_index(input logic [WORD_BITS-1:0] bits);
    logic [5:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (bits[b]) begin
        idx = 6'(b);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/scc_adj_mem.sv =====
module scc_adj_mem #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [scc_pkg::WORD_BITS-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [scc_pkg::WORD_BITS-1:0] rdata
);
  import scc_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/scc_color_mem.sv =====
module scc_color_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [scc_pkg::COLOR_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [scc_pkg::COLOR_W-1:0] rdata
);
  import scc_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/scc_engine.sv =====
module scc_engine #(
  parameter int unsigned MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES,
  localparam int unsigned RowWords = (MAX_VERTICES + 63) / 64,
  localparam int unsigned WW = (RowWords > 1) ? $clog2(RowWords) : 1,
  localparam int unsigned VW = $clog2(MAX_VERTICES),
  localparam int unsigned AW = VW + WW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [9:0]                    in_vertex,
  input  logic [3:0]                    in_word_index,
  input  logic [scc_pkg::WORD_BITS-1:0] in_adj_bits,
  input  logic [scc_pkg::COLOR_W-1:0]   in_color,
  output logic                          res_valid,
  output logic [scc_pkg::VALUE_W-1:0]   res_value,
  input  logic                          res_take,
  output logic                          adj_we,
  output logic [AW-1:0]                 adj_waddr,
  output logic [scc_pkg::WORD_BITS-1:0] adj_wdata,
  output logic [AW-1:0]                 adj_raddr,
  input  logic [scc_pkg::WORD_BITS-1:0] adj_rdata,
  output logic                          col_we,
  output logic [VW-1:0]                 col_waddr,
  output logic [scc_pkg::COLOR_W-1:0]   col_wdata,
  output logic [VW-1:0]                 col_raddr,
  input  logic [scc_pkg::COLOR_W-1:0]   col_rdata
);
  import scc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LO_RD    = 4'd2;
  localparam logic [3:0] S_LO_WAIT  = 4'd3;
  localparam logic [3:0] S_ADJ_RD   = 4'd4;
  localparam logic [3:0] S_ADJ_WAIT = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]           state_r, state_nxt;
  logic [VW-1:0]        clr_r, clr_nxt;
  logic                 hit_vld_r, hit_vld_nxt;
  logic                 energy_r, energy_nxt;
  logic [VW-1:0]        i_r, i_nxt;
  logic [COLOR_W-1:0]   col_r, col_nxt;
  logic [COLOR_W-1:0]   lo_r, lo_nxt;
  logic [WW-1:0]        w_r, w_nxt;
  logic [WORD_BITS-1:0] pend_r, pend_nxt;
  logic [VALUE_W-1:0]   count_r, count_nxt;

  logic [NW-1:0]        n_eff;
  logic [NCOLORS_W-1:0] k_eff;
  logic                 accept;
  logic                 vtx_stored;
  logic [31:0]          base;
  logic [31:0]          n32;
  logic [31:0]          rem;
  logic [WORD_BITS-1:0] word_mask;
  logic [5:0]           scan_idx;
  logic [COLOR_W-1:0]   hi_col, lo_col, diff;
  logic                 hit;
  logic                 last_word;
  logic                 last_row;

  // Effective vertex and colour counts, saturated to what the storage holds
  assign n_eff = (32'(cfg.nverts) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(cfg.nverts);
  assign k_eff = (32'(cfg.ncolors) > MAX_COLORS) ? NCOLORS_W'(MAX_COLORS) : cfg.ncolors;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_stall   = (state_r != S_IDLE);
  assign vtx_stored = 32'(in_vertex) < MAX_VERTICES;

  // Keep only neighbours below the vertex count, and drop the self-loop
  always_comb begin
    base = 32'({w_r, 6'b0});
    n32  = 32'(n_eff);
    rem  = n32 - base;
    if (n32 <= base) begin
      word_mask = '0;
    end else if (rem >= 32'(WORD_BITS)) begin
      word_mask = '1;
    end else begin
      word_mask = (64'd1 << rem[5:0]) - 64'd1;
    end
    if (32'(i_r >> 6) == 32'(w_r)) begin
      word_mask[i_r[5:0]] = 1'b0;
    end
  end

  assign scan_idx = lsb_index(pend_r);

  // One-sided difference test on the colour returned for the last issued read
  assign hi_col = energy_r ? col_rdata : col_r;
  assign lo_col = energy_r ? lo_r : col_rdata;
  assign diff   = hi_col - lo_col;
  assign hit    = (hi_col >= lo_col) && cfg.fmask[diff];

  assign last_word = (32'(w_r) == RowWords - 1);
  assign last_row  = (32'(i_r) + 32'd1 == 32'(n_eff));

  assign adj_raddr = {i_r, w_r};
  assign adj_wdata = in_adj_bits;
  assign adj_waddr = {VW'(in_vertex), WW'(in_word_index)};
  assign adj_we    = accept && (in_cmd == CMD_LOAD_ADJ) && vtx_stored
                     && (32'(in_word_index) < RowWords);

  assign col_raddr = (state_r == S_LO_RD) ? i_r : VW'({w_r, scan_idx});

  assign res_valid = (state_r == S_DONE);
  assign res_value = count_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    energy_nxt  = energy_r;
    i_nxt       = i_r;
    col_nxt     = col_r;
    lo_nxt      = lo_r;
    w_nxt       = w_r;
    pend_nxt    = pend_r;
    count_nxt   = count_r;
    hit_vld_nxt = 1'b0;
    col_we      = 1'b0;
    col_waddr   = VW'(in_vertex);
    col_wdata   = in_color;

    if (hit_vld_r && hit) begin
      count_nxt = count_r + VALUE_W'(1);
    end

    unique case (state_r)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = clr_r;
        col_wdata = '0;
        clr_nxt   = clr_r + VW'(1);
        if (32'(clr_r) == MAX_VERTICES - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          count_nxt = '0;
          w_nxt     = '0;
          col_nxt   = in_color;
          unique case (in_cmd)
            CMD_LOAD_ADJ: begin
            end
            CMD_SET_COLOR: begin
              col_we = vtx_stored;
            end
            CMD_CONFLICT: begin
              energy_nxt = 1'b0;
              i_nxt      = VW'(in_vertex);
              if ((32'(in_vertex) < 32'(n_eff)) && ({1'b0, in_color} < k_eff)) begin
                state_nxt = S_ADJ_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_ENERGY: begin
              energy_nxt = 1'b1;
              i_nxt      = '0;
              state_nxt  = (n_eff == '0) ? S_DONE : S_LO_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_LO_RD: begin
        state_nxt = S_LO_WAIT;
      end
      S_LO_WAIT: begin
        lo_nxt    = col_rdata;
        state_nxt = S_ADJ_RD;
      end
      S_ADJ_RD: begin
        state_nxt = S_ADJ_WAIT;
      end
      S_ADJ_WAIT: begin
        pend_nxt  = adj_rdata & word_mask;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pend_r != '0) begin
          // Issue the colour read for the lowest neighbour and retire its bit
          pend_nxt    = pend_r & (pend_r - 64'd1);
          hit_vld_nxt = 1'b1;
        end else if (!last_word) begin
          w_nxt     = w_r + WW'(1);
          state_nxt = S_ADJ_RD;
        end else if (!energy_r || last_row) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + VW'(1);
          w_nxt     = '0;
          state_nxt = S_LO_RD;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      hit_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      hit_vld_r <= hit_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    energy_r <= energy_nxt;
    i_r      <= i_nxt;
    col_r    <= col_nxt;
    lo_r     <= lo_nxt;
    w_r      <= w_nxt;
    pend_r   <= pend_nxt;
    count_r  <= count_nxt;
  end

endmodule

// ===== design/span_coloring_conflict_eval.sv =====
// Graph colouring conflict evaluator. Holds adjacency rows (64 neighbours per
// word) in one memory and a six-bit colour per vertex in another, and answers
// conflict queries (neighbours of a vertex whose colour sits a forbidden
// difference below a candidate colour) and energy queries (all ordered
// adjacent pairs with a forbidden difference). Each memory has a single read
// port: one row word or one neighbour colour per cycle. After reset the
// colour memory is cleared one entry at a time, during which in_stall stays
// high; configuration writes are taken at any time but belong only to idle
// periods. Row words that were never loaded read as garbage and must not be
// queried.
module span_coloring_conflict_eval #(
  parameter int unsigned MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic [9:0]                     in_vertex,
  input  logic [3:0]                     in_word_index,
  input  logic [63:0]                    in_adj_bits,
  input  logic [5:0]                     in_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [19:0]                    out_value
);
  import scc_pkg::*;

  localparam int unsigned RowWords = (MAX_VERTICES + 63) / 64;
  localparam int unsigned WW       = (RowWords > 1) ? $clog2(RowWords) : 1;
  localparam int unsigned VW       = $clog2(MAX_VERTICES);
  localparam int unsigned AW       = VW + WW;
  localparam int unsigned AdjDepth = MAX_VERTICES * (2 ** WW);

  cfg_t cfg_r, cfg_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   out_value_r;

  logic                 res_valid;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_take;

  logic                 adj_we;
  logic [AW-1:0]        adj_waddr;
  logic [WORD_BITS-1:0] adj_wdata;
  logic [AW-1:0]        adj_raddr;
  logic [WORD_BITS-1:0] adj_rdata;
  logic                 col_we;
  logic [VW-1:0]        col_waddr;
  logic [COLOR_W-1:0]   col_wdata;
  logic [VW-1:0]        col_raddr;
  logic [COLOR_W-1:0]   col_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FORBID_MASK: cfg_nxt.fmask   = cfg_wdata;
        CFG_NUM_VERTS:   cfg_nxt.nverts  = cfg_wdata[NVERTS_W-1:0];
        CFG_NUM_COLORS:  cfg_nxt.ncolors = cfg_wdata[NCOLORS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmask   <= 64'd1;
      cfg_r.nverts  <= NVERTS_W'(1024);
      cfg_r.ncolors <= NCOLORS_W'(64);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Output register: the engine may finish while an earlier result waits
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  scc_engine #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_vertex     (in_vertex),
    .in_word_index (in_word_index),
    .in_adj_bits   (in_adj_bits),
    .in_color      (in_color),
    .res_valid     (res_valid),
    .res_value     (res_value),
    .res_take      (res_take),
    .adj_we        (adj_we),
    .adj_waddr     (adj_waddr),
    .adj_wdata     (adj_wdata),
    .adj_raddr     (adj_raddr),
    .adj_rdata     (adj_rdata),
    .col_we        (col_we),
    .col_waddr     (col_waddr),
    .col_wdata     (col_wdata),
    .col_raddr     (col_raddr),
    .col_rdata     (col_rdata)
  );

  scc_adj_mem #(
    .DEPTH (AdjDepth)
  ) u_adj_mem (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  scc_color_mem #(
    .DEPTH (MAX_VERTICES)
  ) u_color_mem (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

endmodule

// ===== verif/tb_span_coloring_conflict_eval.sv =====
class conflict_scoreboard;
  localparam int unsigned NV = scc_pkg::DEF_MAX_VERTICES;
  localparam int unsigned ROW_WORDS = (NV + 63) / 64;

  bit [63:0] adj_rows [NV*ROW_WORDS];
  bit [scc_pkg::COLOR_W-1:0] vertex_colors [NV];
  bit [63:0] fmask;
  bit [scc_pkg::NVERTS_W-1:0] nverts;
  bit [scc_pkg::NCOLORS_W-1:0] ncolors;
  bit [scc_pkg::VALUE_W-1:0] awaited_counts [$];
  int errors;

  function new();
    fmask = 64'd1;
    nverts = scc_pkg::NVERTS_W'(NV);
    ncolors = scc_pkg::NCOLORS_W'(scc_pkg::MAX_COLORS);
    errors = 0;
  endfunction

  function void write_reg(bit [scc_pkg::CFG_IDX_W-1:0] idx, bit [63:0] data);
    if (idx == scc_pkg::CFG_FORBID_MASK) begin
      fmask = data;
    end else if (idx == scc_pkg::CFG_NUM_VERTS) begin
      nverts = data[scc_pkg::NVERTS_W-1:0];
    end else if (idx == scc_pkg::CFG_NUM_COLORS) begin
      ncolors = data[scc_pkg::NCOLORS_W-1:0];
    end
  endfunction

  function int unsigned active_vertices();
    return (nverts > NV) ? NV : int'(nverts);
  endfunction

  function int unsigned active_colors();
    return (ncolors > scc_pkg::MAX_COLORS) ? scc_pkg::MAX_COLORS : int'(ncolors);
  endfunction

  // Only non-negative differences can be forbidden
  function bit forbidden(bit [5:0] hi, bit [5:0] lo);
    if (hi < lo) begin
      return 1'b0;
    end
    return fmask[hi - lo];
  endfunction

  // energy_mode: difference is colour(v) - colour(i); else candidate - colour(v)
  function int unsigned count_forbidden(int unsigned i, int unsigned n, bit [5:0] cand,
                                        bit energy_mode);
    int unsigned hits;
    int unsigned v;
    bit [63:0] bits;
    hits = 0;
    for (int unsigned w = 0; w < ROW_WORDS; w++) begin
      bits = adj_rows[i*ROW_WORDS + w];
      if (bits == 64'd0) begin
        continue;
      end
      for (int unsigned j = 0; j < 64; j++) begin
        v = w*64 + j;
        if (!bits[j] || v >= n || v == i) begin
          continue;
        end
        if (energy_mode ? forbidden(vertex_colors[v], vertex_colors[i])
                        : forbidden(cand, vertex_colors[v])) begin
          hits++;
        end
      end
    end
    return hits;
  endfunction

  function void take_item(bit [1:0] cmd, bit [9:0] vertex, bit [3:0] widx,
                          bit [63:0] bits, bit [5:0] color);
    int unsigned n;
    int unsigned total;
    n = active_vertices();
    total = 0;
    if (cmd == scc_pkg::CMD_LOAD_ADJ) begin
      if (vertex < NV && widx < ROW_WORDS) begin
        adj_rows[vertex*ROW_WORDS + widx] = bits;
      end
    end else if (cmd == scc_pkg::CMD_SET_COLOR) begin
      if (vertex < NV) begin
        vertex_colors[vertex] = color;
      end
    end else begin
      if (cmd == scc_pkg::CMD_CONFLICT) begin
        if (vertex < n && color < active_colors()) begin
          total = count_forbidden(vertex, n, color, 1'b0);
        end
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          total += count_forbidden(i, n, 6'd0, 1'b1);
        end
      end
      awaited_counts = {awaited_counts, total[scc_pkg::VALUE_W-1:0]};
    end
  endfunction

  function void check_value(bit [scc_pkg::VALUE_W-1:0] value);
    bit [scc_pkg::VALUE_W-1:0] want;
    if (awaited_counts.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %0d", $time, value);
      return;
    end
    want = awaited_counts.pop_front();
    if (value != want) begin
      errors++;
      $display("%0t: value mismatch, expected %0d, got %0d", $time, want, value);
    end
  endfunction

  function int pending();
    return awaited_counts.size();
  endfunction
endclass

module tb_span_coloring_conflict_eval;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int unsigned NV = DEF_MAX_VERTICES;
  localparam int unsigned ROW_WORDS = (NV + 63) / 64;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_cmd;
  logic [9:0]            in_vertex;
  logic [3:0]            in_word_index;
  logic [63:0]           in_adj_bits;
  logic [5:0]            in_color;
  logic                  out_valid;
  logic                  out_stall;
  logic [19:0]           out_value;

  span_coloring_conflict_eval dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_vertex    (in_vertex),
    .in_word_index(in_word_index),
    .in_adj_bits  (in_adj_bits),
    .in_color     (in_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  conflict_scoreboard sb;

  bit [ROW_WORDS-1:0] words_loaded [NV];
  int unsigned        full_rows [$];
  int unsigned        full_prefix;
  int unsigned        cur_n;
  int unsigned        cur_k;
  int unsigned        burst_left;
  bit                 hold_req;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly sparse rows keep query latency low
  function automatic logic [63:0] rand_adj();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '1;
    if (r < 8) return '0;
    if (r < 25) return rand64();
    return rand64() & rand64() & rand64();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_full_row();
    return full_rows[$urandom_range(0, full_rows.size() - 1)];
  endfunction

  function automatic int unsigned pick_color();
    if (cur_k > 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, cur_k - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic void mark_loaded(int unsigned v, int unsigned w);
    if (&words_loaded[v]) return;
    words_loaded[v][w] = 1'b1;
    if (&words_loaded[v]) begin
      full_rows = {full_rows, v};
      while (full_prefix < NV && &words_loaded[full_prefix]) full_prefix++;
    end
  endfunction

  // Leaves valid high after the transfer; callers that wait must drop it
  task automatic send_item(logic [1:0] cmd, int unsigned v, int unsigned w,
                           logic [63:0] bits, int unsigned c);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_vertex     <= v[9:0];
    in_word_index <= w[3:0];
    in_adj_bits   <= bits;
    in_color      <= c[5:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(cmd, v[9:0], w[3:0], bits, c[5:0]);
    if (cmd == CMD_LOAD_ADJ) mark_loaded(v[9:0], w[3:0]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] mask, int unsigned n, int unsigned k);
    logic [63:0] junk_n;
    logic [63:0] junk_k;
    junk_n = rand64();
    junk_k = rand64();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FORBID_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_NUM_VERTS;
    cfg_wdata <= {junk_n[63:11], n[10:0]};
    @(posedge clk);
    cfg_index <= CFG_NUM_COLORS;
    cfg_wdata <= {junk_k[63:7], k[6:0]};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(CFG_FORBID_MASK, mask);
    sb.write_reg(CFG_NUM_VERTS, {junk_n[63:11], n[10:0]});
    sb.write_reg(CFG_NUM_COLORS, {junk_k[63:7], k[6:0]});
    cur_n = sb.active_vertices();
    cur_k = sb.active_colors();
  endtask

  task automatic run_mix(int unsigned count);
    int unsigned sent;
    int unsigned r;
    int unsigned v;
    int unsigned c;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Fill a whole row, often extending the loaded prefix, then query it
        v = ($urandom_range(0, 1) != 0 && full_prefix < NV) ? full_prefix
                                                            : $urandom_range(0, NV - 1);
        for (int unsigned w = 0; w < ROW_WORDS; w++) begin
          send_item(CMD_LOAD_ADJ, v, w, rand_adj(), $urandom);
        end
        send_item(CMD_CONFLICT, v, $urandom, rand64(), pick_color());
        sent += ROW_WORDS + 1;
      end else if (r < 30) begin
        v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 63) : $urandom_range(0, NV - 1);
        send_item(CMD_SET_COLOR, v, $urandom, rand64(), $urandom);
        sent++;
      end else if (r < 68) begin
        send_item(CMD_CONFLICT, pick_full_row(), $urandom, rand64(), pick_color());
        sent++;
      end else if (r < 78 && cur_n <= full_prefix) begin
        send_item(CMD_ENERGY, $urandom, $urandom, rand64(), $urandom);
        sent++;
      end else if (r < 90) begin
        send_item(CMD_LOAD_ADJ, $urandom_range(0, NV - 1), $urandom, rand64(), $urandom);
        sent++;
      end else begin
        // Out-of-range candidate or vertex answers zero without a row walk; else a loaded row
        if (cur_k < MAX_COLORS && $urandom_range(0, 1) != 0) begin
          v = $urandom_range(0, NV - 1);
          c = $urandom_range(cur_k, 63);
        end else if (cur_n < NV) begin
          v = $urandom_range(cur_n, NV - 1);
          c = $urandom_range(0, 63);
        end else begin
          v = pick_full_row();
          c = pick_color();
        end
        send_item(CMD_CONFLICT, v, $urandom, rand64(), c);
        sent++;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned r;
    stall_left = 0;
    free_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_value(out_value);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        free_left = 0;
      end else if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 45) free_left = $urandom_range(1, 8);
        else if (r < 60) free_left = $urandom_range(30, 150);
        else if (r < 92) stall_left = $urandom_range(1, 4);
        else stall_left = $urandom_range(15, 60);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end
    end
  end

  initial begin : stimulus
    logic [63:0] mask;
    int unsigned n;
    int unsigned k;
    sb = new();
    cur_n = NV;
    cur_k = MAX_COLORS;
    full_prefix = 0;
    burst_left = 0;
    hold_req = 1'b0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_FORBID_MASK;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_LOAD_ADJ;
    in_vertex     <= '0;
    in_word_index <= '0;
    in_adj_bits   <= '0;
    in_color      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Load the first rows completely so energy queries have something to walk
    for (int unsigned v = 0; v < 8; v++) begin
      for (int unsigned w = 0; w < ROW_WORDS; w++) begin
        send_item(CMD_LOAD_ADJ, v, w, rand_adj(), $urandom);
      end
    end

    // Reset settings: same colour forbidden, full graph, all colours
    send_item(CMD_SET_COLOR, NV - 1, 0, '0, 63);
    send_item(CMD_SET_COLOR, 5, 15, '1, 63);
    send_item(CMD_LOAD_ADJ, 0, 0, '1, 0);
    send_item(CMD_LOAD_ADJ, 0, ROW_WORDS - 1, '1, 63);
    send_item(CMD_CONFLICT, 0, 0, '0, 63);
    send_item(CMD_CONFLICT, 0, 0, '0, 0);
    send_item(CMD_LOAD_ADJ, NV - 1, ROW_WORDS - 1, '0, 0);
    send_item(CMD_CONFLICT, 1, 0, '0, 63);
    run_mix(40);

    // No vertices and no colours in use
    drain();
    configure('1, 0, 0);
    send_item(CMD_CONFLICT, 0, 0, '0, 0);
    send_item(CMD_ENERGY, 0, 0, '0, 0);
    run_mix(40);

    // Counts above the storage saturate; empty mask
    drain();
    configure('0, 2047, 127);
    send_item(CMD_CONFLICT, 0, 0, '0, 63);
    run_mix(40);

    // Every difference forbidden, a single colour, small graph
    drain();
    configure('1, 8, 1);
    send_item(CMD_ENERGY, 0, 0, '0, 0);
    send_item(CMD_CONFLICT, 0, 0, '0, 0);
    send_item(CMD_CONFLICT, 0, 0, '0, 1);
    send_item(CMD_CONFLICT, 9, 0, '0, 0);
    send_item(CMD_SET_COLOR, 9, 0, '0, 7);
    run_mix(40);

    // Only the largest and smallest differences forbidden, one vertex
    drain();
    configure(64'h8000_0000_0000_0001, 1, 64);
    send_item(CMD_ENERGY, 0, 0, '0, 0);
    send_item(CMD_CONFLICT, 0, 0, '0, 63);
    run_mix(40);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: mask = rand64();
        1: mask = rand64() & rand64() & rand64();
        2: mask = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
        default: mask = '1;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: n = $urandom_range(0, full_prefix);
        4, 5, 6: n = $urandom_range(1, 64);
        7, 8: n = NV;
        default: n = $urandom_range(NV + 1, 2047);
      endcase
      case ($urandom_range(0, 4))
        0: k = $urandom_range(0, 127);
        1: k = MAX_COLORS;
        default: k = $urandom_range(1, MAX_COLORS);
      endcase
      configure(mask, n, k);
      if (ph == 2) begin
        // Hold off the result side while queries keep coming
        hold_req = 1'b1;
        repeat (14) send_item(CMD_CONFLICT, pick_full_row(), $urandom, rand64(), pick_color());
      end
      run_mix(45);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/scc_pkg.sv
design/scc_adj_mem.sv
design/scc_color_mem.sv
design/scc_engine.sv
design/span_coloring_conflict_eval.sv
verif/tb_span_coloring_conflict_eval.sv
